>>> src/shsort_pkg.sv
// Shared constants and controller/datapath interface types for the Shell sort block.
// No dependencies; imported by every other module in the project.
package shsort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DATA_W       = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store the incoming element if there is room
        logic init_gap;    // gap := 1
        logic grow_gap;    // gap := 2 * gap + 1
        logic shrink_gap;  // gap := (gap - 1) / 2
        logic start_pass;  // outer := gap, inner := gap
        logic next_outer;  // outer := outer + 1, inner := outer + 1
        logic read_pair;   // fetch store[inner] and store[inner - gap]
        logic swap_hi;     // store[inner] := lower element
        logic swap_lo;     // store[inner - gap] := upper element, inner -= gap
        logic emit_start;  // emission index := 0
        logic emit_read;   // fetch store[emission index]
        logic emit_load;   // present the fetched element on the output
        logic emit_next;   // emission index += 1
        logic clr_count;   // run finished, element count := 0
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gap_lt_half;  // gap < count / 2
        logic gap_is_one;   // gap <= 1
        logic outer_lt_n;   // outer < count
        logic inner_ge_gap; // inner >= gap
        logic less;         // upper element < lower element (signed)
        logic out_taken;    // output transaction completes this cycle
        logic out_last;     // the element on the output closes the run
    } t_status;

endpackage

>>> src/shsort_ctrl.sv
// Controller state machine of the Shell sort block.
// Depends on shsort_pkg; drives commands into shsort_dp.
module shsort_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_final_item,
    output logic              o_stall,
    input  shsort_pkg::t_status i_status,
    output shsort_pkg::t_cmd    o_cmd
);
    import shsort_pkg::*;

    typedef enum logic [13:0] {
        S_LOAD       = 14'b00000000000001,
        S_GROW       = 14'b00000000000010,
        S_PASS_START = 14'b00000000000100,
        S_PASS_CHECK = 14'b00000000001000,
        S_READ       = 14'b00000000010000,
        S_CMP        = 14'b00000000100000,
        S_SWAP_HI    = 14'b00000001000000,
        S_SWAP_LO    = 14'b00000010000000,
        S_JCHK       = 14'b00000100000000,
        S_NEXT_I     = 14'b00001000000000,
        S_NEXT_GAP   = 14'b00010000000000,
        S_EMIT_RD    = 14'b00100000000000,
        S_EMIT_LD    = 14'b01000000000000,
        S_EMIT_WT    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   in_acc;

    assign o_stall = (r_state != S_LOAD);
    assign in_acc  = i_valid && (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_final_item) begin
                        o_cmd.init_gap = 1'b1;
                        n_state        = S_GROW;
                    end
                end
            end
            S_GROW: begin
                if (i_status.gap_lt_half) begin
                    o_cmd.grow_gap = 1'b1;
                end else begin
                    n_state = S_PASS_START;
                end
            end
            S_PASS_START: begin
                o_cmd.start_pass = 1'b1;
                n_state          = S_PASS_CHECK;
            end
            S_PASS_CHECK: begin
                n_state = i_status.outer_lt_n ? S_READ : S_NEXT_GAP;
            end
            S_READ: begin
                o_cmd.read_pair = 1'b1;
                n_state         = S_CMP;
            end
            S_CMP: begin
                n_state = i_status.less ? S_SWAP_HI : S_NEXT_I;
            end
            S_SWAP_HI: begin
                o_cmd.swap_hi = 1'b1;
                n_state       = S_SWAP_LO;
            end
            S_SWAP_LO: begin
                o_cmd.swap_lo = 1'b1;
                n_state       = S_JCHK;
            end
            S_JCHK: begin
                n_state = i_status.inner_ge_gap ? S_READ : S_NEXT_I;
            end
            S_NEXT_I: begin
                o_cmd.next_outer = 1'b1;
                n_state          = S_PASS_CHECK;
            end
            S_NEXT_GAP: begin
                if (i_status.gap_is_one) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_EMIT_RD;
                end else begin
                    o_cmd.shrink_gap = 1'b1;
                    n_state          = S_PASS_START;
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_read = 1'b1;
                n_state         = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_cmd.emit_load = 1'b1;
                n_state         = S_EMIT_WT;
            end
            S_EMIT_WT: begin
                if (i_status.out_taken) begin
                    if (i_status.out_last) begin
                        o_cmd.clr_count = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/shsort_dp.sv
// Datapath of the Shell sort block: element store, index registers, comparator, output register.
// Depends on shsort_pkg; commanded by shsort_ctrl.
module shsort_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [shsort_pkg::DATA_W-1:0] i_value,
    input  logic                          i_stall,
    output logic signed [shsort_pkg::DATA_W-1:0] o_sorted_value,
    output logic                          o_end_of_run,
    output logic                          o_valid,
    input  shsort_pkg::t_cmd              i_cmd,
    output shsort_pkg::t_status           o_status
);
    import shsort_pkg::*;

    logic [DATA_W-1:0] r_mem [MAX_ELEMENTS];

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_gap;
    logic [CNT_W-1:0]  r_outer;
    logic [CNT_W-1:0]  r_inner;
    logic [CNT_W-1:0]  r_emit;
    logic [DATA_W-1:0] r_rd_hi;
    logic [DATA_W-1:0] r_rd_lo;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_last;
    logic              r_out_valid;

    logic [CNT_W-1:0]  lower_idx;
    logic [CNT_W-1:0]  emit_inc;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr_hi;
    logic              room;

    assign lower_idx = r_inner - r_gap;
    assign emit_inc  = r_emit + CNT_W'(1);
    assign room      = (r_count < CNT_W'(MAX_ELEMENTS));

    // Single write port shared by loading and the two halves of a swap.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[ADDR_W-1:0];
        wr_data = i_value;
        if (i_cmd.load && room) begin
            wr_en = 1'b1;
        end else if (i_cmd.swap_hi) begin
            wr_en   = 1'b1;
            wr_addr = r_inner[ADDR_W-1:0];
            wr_data = r_rd_lo;
        end else if (i_cmd.swap_lo) begin
            wr_en   = 1'b1;
            wr_addr = lower_idx[ADDR_W-1:0];
            wr_data = r_rd_hi;
        end
    end

    assign rd_addr_hi = i_cmd.emit_read ? r_emit[ADDR_W-1:0] : r_inner[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.read_pair || i_cmd.emit_read) begin
            r_rd_hi <= r_mem[rd_addr_hi];
        end
        if (i_cmd.read_pair) begin
            r_rd_lo <= r_mem[lower_idx[ADDR_W-1:0]];
        end
    end

    // Index registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_gap) begin
            r_gap <= CNT_W'(1);
        end else if (i_cmd.grow_gap) begin
            r_gap <= {r_gap[CNT_W-2:0], 1'b1};
        end else if (i_cmd.shrink_gap) begin
            r_gap <= (r_gap - CNT_W'(1)) >> 1;
        end
        if (i_cmd.start_pass) begin
            r_outer <= r_gap;
            r_inner <= r_gap;
        end else if (i_cmd.next_outer) begin
            r_outer <= r_outer + CNT_W'(1);
            r_inner <= r_outer + CNT_W'(1);
        end else if (i_cmd.swap_lo) begin
            r_inner <= lower_idx;
        end
        if (i_cmd.emit_start) begin
            r_emit <= '0;
        end else if (i_cmd.emit_next) begin
            r_emit <= emit_inc;
        end
        if (i_cmd.emit_load) begin
            r_out_value <= r_rd_hi;
            r_out_last  <= (emit_inc == r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.load && room) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.gap_lt_half  = (r_gap < (r_count >> 1));
    assign o_status.gap_is_one   = (r_gap <= CNT_W'(1));
    assign o_status.outer_lt_n   = (r_outer < r_count);
    assign o_status.inner_ge_gap = (r_inner >= r_gap);
    assign o_status.less         = ($signed(r_rd_hi) < $signed(r_rd_lo));
    assign o_status.out_taken    = r_out_valid && !i_stall;
    assign o_status.out_last     = r_out_last;

    assign o_sorted_value = r_out_value;
    assign o_end_of_run   = r_out_last;
    assign o_valid        = r_out_valid;

endmodule

>>> src/shell_sort_hibbard_top.sv
// Shell sort block with Hibbard-style gaps: loads a run, sorts it in a 64-entry store, emits it.
// Loading takes one element per cycle while input stall is low; then the gap grows. Each compare
// reads and compares a pair; each swap writes both elements through the store's single write port.
// Emission reads each element, loads the output register and waits until the element is taken.
// Throughput: one run at a time; input stall stays high from the final element until the last
// sorted element is taken. Reset clears the controller, element count and output valid only.
module shell_sort_hibbard_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [shsort_pkg::DATA_W-1:0] i_value,
    input  logic                                 i_final_item,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    output logic signed [shsort_pkg::DATA_W-1:0] o_sorted_value,
    output logic                                 o_end_of_run,
    output logic                                 o_valid,
    input  logic                                 i_stall
);
    import shsort_pkg::*;

    // The controller sequences loading, gap growth, the gapped insertion passes
    // and emission; every data and index register lives in the datapath.
    t_cmd    cmd;
    t_status status;

    shsort_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_final_item (i_final_item),
        .o_stall      (o_stall),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // The datapath holds the element store, which is read only at entries
    // written during the current run, so it needs no clearing after reset.
    shsort_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_end_of_run   (o_end_of_run),
        .o_valid        (o_valid),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule
